// File: rtl/lwli_pkg.sv
package lwli_pkg;

   // Field widths
   localparam int POS_W          = 16;
   localparam int WT_W           = 16;
   localparam int COST_W         = 48;
   localparam int STATUS_W       = 2;
   localparam int CIDX_W         = 7;
   localparam int MAX_POINTS_DEF = 64;

   localparam logic [COST_W-1:0] COST_MAX = {COST_W{1'b1}};

   // Result status codes
   localparam logic [STATUS_W-1:0] STATUS_OK        = 2'd0;
   localparam logic [STATUS_W-1:0] STATUS_BAD_START = 2'd1;
   localparam logic [STATUS_W-1:0] STATUS_ORDER     = 2'd2;

   typedef struct packed {
      logic [POS_W-1:0] position;
      logic [WT_W-1:0]  weight;
      logic             last;
   } req_type;

   typedef struct packed {
      logic [COST_W-1:0]   min_cost;
      logic [STATUS_W-1:0] status;
   } rsp_type;

   // Add, clamping at the cost maximum
   function automatic logic [COST_W-1:0] sat_add(input logic [COST_W-1:0] a,
                                                 input logic [COST_W-1:0] b);
      logic [COST_W:0] s;
      s = {1'b0, a} + {1'b0, b};
      return s[COST_W] ? COST_MAX : s[COST_W-1:0];
   endfunction

   function automatic logic [COST_W-1:0] cost_min(input logic [COST_W-1:0] a,
                                                  input logic [COST_W-1:0] b);
      return (a < b) ? a : b;
   endfunction

endpackage

// File: rtl/line_weighted_latency_interval_dp.sv
// Minimum weighted waiting cost of a walker on a line. Points arrive one per req transfer
// (position, weight, last), positions nondecreasing; points are taken only while idle and
// points beyond MAX_POINTS are dropped. The transfer with last set closes the set: the block
// then runs an interval DP from the start index held in the csr register, each DP cell
// stepping through states ST_CRD and ST_CM0 to ST_CM5 with one shared multiplier and one
// point-memory read port, after row setup in states ST_ROW0 to ST_ROW3. No point is taken
// while the solve runs. A bad start index (zero or beyond the point count) gives status 1,
// decreasing positions give status 2, both with cost 0. Costs saturate at the 48-bit
// maximum. The csr port is always ready and must only be written while the block is idle.
module line_weighted_latency_interval_dp #(
   parameter int MAX_POINTS = lwli_pkg::MAX_POINTS_DEF
) (
   input  logic                            clock,
   input  logic                            reset,
   input  logic                            req_valid,
   output logic                            req_ready,
   input  lwli_pkg::req_type               req_data,
   output logic                            rsp_valid,
   input  logic                            rsp_ready,
   output lwli_pkg::rsp_type               rsp_data,
   input  logic                            csr_valid,
   output logic                            csr_ready,
   input  logic [lwli_pkg::CIDX_W-1:0]     csr_data
);

   localparam int PW   = lwli_pkg::POS_W;
   localparam int CSTW = lwli_pkg::COST_W;
   localparam int AW   = $clog2(MAX_POINTS);
   localparam int NW   = $clog2(MAX_POINTS + 2);
   localparam int SW   = $clog2(MAX_POINTS * ((2 ** lwli_pkg::WT_W) - 1) + 1);
   localparam int CW   = (NW > lwli_pkg::CIDX_W) ? NW : lwli_pkg::CIDX_W;
   localparam int PRW  = PW + SW;
   localparam int EW   = PW + SW;

   typedef enum logic [12:0] {
      ST_IDLE = 13'b0000000000001,
      ST_ROW0 = 13'b0000000000010,
      ST_ROW1 = 13'b0000000000100,
      ST_ROW2 = 13'b0000000001000,
      ST_ROW3 = 13'b0000000010000,
      ST_CRD  = 13'b0000000100000,
      ST_CM0  = 13'b0000001000000,
      ST_CM1  = 13'b0000010000000,
      ST_CM2  = 13'b0000100000000,
      ST_CM3  = 13'b0001000000000,
      ST_CM4  = 13'b0010000000000,
      ST_CM5  = 13'b0100000000000,
      ST_OUT  = 13'b1000000000000
   } state_type;

   state_type state_ff, state_in;

   // Load state
   logic [NW-1:0]                  cnt_ff, cnt_in;
   logic [SW-1:0]                  psum_ff, psum_in;
   logic [PW-1:0]                  lastpos_ff, lastpos_in;
   logic                           viol_ff, viol_in;
   logic [lwli_pkg::CIDX_W-1:0]    start_ff;

   // Solve state
   logic [NW-1:0]   n_ff, n_in, i_ff, i_in, j_ff, j_in;
   logic [SW-1:0]   pn_ff, pn_in, p_i_ff, p_i_in, p_im1_ff, p_im1_in;
   logic [SW-1:0]   p_prev_ff, p_prev_in, pj_ff, pj_in;
   logic [PW-1:0]   pos_i_ff, pos_i_in, pos_i1_ff, pos_i1_in;
   logic [PW-1:0]   pos_prev_ff, pos_prev_in, posj_ff, posj_in;
   logic [CSTW-1:0] prevl_ff, prevl_in, prevr_ff, prevr_in;
   logic [CSTW-1:0] oldl_ff, oldl_in, oldr_ff, oldr_in;
   logic [CSTW-1:0] acc_ff, acc_in, newl_ff, newl_in;
   logic [PRW-1:0]  prod_ff, prod_in;
   logic [CSTW-1:0] res_cost_ff, res_cost_in;
   logic [lwli_pkg::STATUS_W-1:0] res_status_ff, res_status_in;

   // Result register
   logic              rsp_valid_ff, rsp_valid_in;
   lwli_pkg::rsp_type rsp_data_ff, rsp_data_in;

   // Memories
   logic            pt_we;
   logic [AW-1:0]   pt_waddr, pt_raddr;
   logic [EW-1:0]   pt_wdata, pt_rdata;
   logic            row_we;
   logic [AW-1:0]   row_addr;
   logic [2*CSTW-1:0] row_wdata, row_rdata;
   logic [PW-1:0]   rd_pos;
   logic [SW-1:0]   rd_psum;

   // Datapath helpers
   logic            req_fire, in_room, bad_start, viol_nx, slot_free;
   logic [NW-1:0]   cnt_nx, c_n, jst, pt_idx;
   logic [SW-1:0]   psum_nx, w1, w2, w_b;
   logic [PW-1:0]   g_a, g_ij, g_j, gap_a;
   logic [CSTW-1:0] prod_c, add_a, sum_s, min_s, newr;

   lwli_ram #(.DEPTH(MAX_POINTS), .AW(AW), .DW(EW)) u_point_ram (
      .clock   (clock),
      .wr_en   (pt_we),
      .wr_addr (pt_waddr),
      .wr_data (pt_wdata),
      .rd_addr (pt_raddr),
      .rd_data (pt_rdata)
   );

   lwli_ram #(.DEPTH(MAX_POINTS), .AW(AW), .DW(2*CSTW)) u_row_ram (
      .clock   (clock),
      .wr_en   (row_we),
      .wr_addr (row_addr),
      .wr_data (row_wdata),
      .rd_addr (row_addr),
      .rd_data (row_rdata)
   );

   assign rd_pos  = pt_rdata[EW-1:SW];
   assign rd_psum = pt_rdata[SW-1:0];

   assign req_ready = (state_ff == ST_IDLE);
   assign req_fire  = req_valid && req_ready;
   assign csr_ready = 1'b1;
   assign rsp_valid = rsp_valid_ff;
   assign rsp_data  = rsp_data_ff;
   assign slot_free = !rsp_valid_ff || rsp_ready;

   // Load arithmetic
   assign in_room   = (cnt_ff < NW'(MAX_POINTS));
   assign psum_nx   = psum_ff + SW'(req_data.weight);
   assign cnt_nx    = cnt_ff + NW'(in_room);
   assign viol_nx   = viol_ff | (in_room && (cnt_ff != '0) && (req_data.position < lastpos_ff));
   assign bad_start = (start_ff == '0) || (CW'(start_ff) > CW'(cnt_nx));
   assign c_n       = NW'(start_ff);
   assign jst       = (i_ff == c_n) ? (c_n + NW'(1)) : c_n;

   // Point memory write during loading
   assign pt_we    = req_fire && in_room;
   assign pt_waddr = AW'(cnt_ff);
   assign pt_wdata = {req_data.position, psum_nx};

   // Point memory read address
   always_comb begin
      unique case (state_ff)
         ST_ROW0: begin
            pt_idx = i_ff - NW'(1);
         end
         ST_ROW1: begin
            pt_idx = i_ff;
         end
         ST_ROW2: begin
            pt_idx = i_ff - NW'(2);
         end
         default: begin
            pt_idx = j_ff - NW'(1);
         end
      endcase
   end
   assign pt_raddr = AW'(pt_idx);

   // Row memory: both rows in one word, indexed by right end
   assign row_addr  = AW'(j_ff - NW'(1));
   assign row_we    = (state_ff == ST_CM5);
   assign row_wdata = {newl_ff, newr};

   // Cell terms
   assign w1   = pn_ff - pj_ff + p_i_ff;
   assign w2   = pn_ff - p_prev_ff + p_im1_ff;
   assign g_a  = pos_i1_ff - pos_i_ff;
   assign g_ij = posj_ff - pos_i_ff;
   assign g_j  = posj_ff - pos_prev_ff;

   // Shared multiplier operands
   always_comb begin
      unique case (state_ff)
         ST_CM2: begin
            gap_a = g_ij;
            w_b   = w1;
         end
         ST_CM3: begin
            gap_a = g_ij;
            w_b   = w2;
         end
         ST_CM4: begin
            gap_a = g_j;
            w_b   = w2;
         end
         default: begin
            gap_a = g_a;
            w_b   = w1;
         end
      endcase
   end
   assign prod_in = PRW'(gap_a) * PRW'(w_b);
   assign prod_c  = CSTW'(prod_ff);

   // Shared saturating adder and compare
   always_comb begin
      unique case (state_ff)
         ST_CM2: begin
            add_a = oldl_ff;
         end
         ST_CM3: begin
            add_a = oldr_ff;
         end
         ST_CM4: begin
            add_a = prevl_ff;
         end
         default: begin
            add_a = prevr_ff;
         end
      endcase
   end
   assign sum_s = lwli_pkg::sat_add(add_a, prod_c);
   assign min_s = lwli_pkg::cost_min(acc_ff, sum_s);
   assign newr  = min_s;

   // Sequencer
   always_comb begin
      state_in      = state_ff;
      cnt_in        = cnt_ff;
      psum_in       = psum_ff;
      lastpos_in    = lastpos_ff;
      viol_in       = viol_ff;
      n_in          = n_ff;
      pn_in         = pn_ff;
      i_in          = i_ff;
      j_in          = j_ff;
      p_i_in        = p_i_ff;
      p_im1_in      = p_im1_ff;
      p_prev_in     = p_prev_ff;
      pj_in         = pj_ff;
      pos_i_in      = pos_i_ff;
      pos_i1_in     = pos_i1_ff;
      pos_prev_in   = pos_prev_ff;
      posj_in       = posj_ff;
      prevl_in      = prevl_ff;
      prevr_in      = prevr_ff;
      oldl_in       = oldl_ff;
      oldr_in       = oldr_ff;
      acc_in        = acc_ff;
      newl_in       = newl_ff;
      res_cost_in   = res_cost_ff;
      res_status_in = res_status_ff;
      rsp_valid_in  = rsp_valid_ff && !rsp_ready;
      rsp_data_in   = rsp_data_ff;

      unique case (state_ff)
         ST_IDLE: begin
            if (req_fire) begin
               if (req_data.last) begin
                  // Close the set and decide the outcome
                  n_in          = cnt_nx;
                  pn_in         = in_room ? psum_nx : psum_ff;
                  cnt_in        = '0;
                  psum_in       = '0;
                  viol_in       = 1'b0;
                  res_cost_in   = '0;
                  res_status_in = lwli_pkg::STATUS_OK;
                  i_in          = c_n;
                  priority if (bad_start) begin
                     res_status_in = lwli_pkg::STATUS_BAD_START;
                     state_in      = ST_OUT;
                  end else if (viol_nx) begin
                     res_status_in = lwli_pkg::STATUS_ORDER;
                     state_in      = ST_OUT;
                  end else if (cnt_nx == NW'(1)) begin
                     state_in = ST_OUT;
                  end else begin
                     state_in = ST_ROW0;
                  end
               end else if (in_room) begin
                  cnt_in     = cnt_nx;
                  psum_in    = psum_nx;
                  viol_in    = viol_nx;
                  lastpos_in = req_data.position;
               end
            end
         end
         ST_ROW0: begin
            state_in = ST_ROW1;
         end
         ST_ROW1: begin
            pos_i_in = rd_pos;
            p_i_in   = rd_psum;
            state_in = ST_ROW2;
         end
         ST_ROW2: begin
            pos_i1_in = rd_pos;
            state_in  = ST_ROW3;
         end
         ST_ROW3: begin
            // Seed the left neighbour of the first cell in the row
            p_im1_in    = (i_ff >= NW'(2)) ? rd_psum : '0;
            pos_prev_in = pos_i_ff;
            p_prev_in   = p_i_ff;
            j_in        = jst;
            if (i_ff == c_n) begin
               prevl_in = '0;
               prevr_in = '0;
            end else begin
               prevl_in = lwli_pkg::COST_MAX;
               prevr_in = lwli_pkg::COST_MAX;
            end
            priority if (jst <= n_ff) begin
               state_in = ST_CRD;
            end else if (i_ff == NW'(1)) begin
               state_in = ST_OUT;
            end else begin
               i_in     = i_ff - NW'(1);
               state_in = ST_ROW0;
            end
         end
         ST_CRD: begin
            state_in = ST_CM0;
         end
         ST_CM0: begin
            // Latch point data and the previous row's pair
            posj_in = rd_pos;
            pj_in   = rd_psum;
            priority if (i_ff == c_n) begin
               oldl_in = lwli_pkg::COST_MAX;
               oldr_in = lwli_pkg::COST_MAX;
            end else if ((j_ff == c_n) && (i_ff == c_n - NW'(1))) begin
               oldl_in = '0;
               oldr_in = '0;
            end else begin
               oldl_in = row_rdata[2*CSTW-1:CSTW];
               oldr_in = row_rdata[CSTW-1:0];
            end
            state_in = ST_CM1;
         end
         ST_CM1: begin
            state_in = ST_CM2;
         end
         ST_CM2: begin
            acc_in   = sum_s;
            state_in = ST_CM3;
         end
         ST_CM3: begin
            newl_in  = min_s;
            state_in = ST_CM4;
         end
         ST_CM4: begin
            acc_in   = sum_s;
            state_in = ST_CM5;
         end
         ST_CM5: begin
            // Write back the cell and step along the row
            prevl_in    = newl_ff;
            prevr_in    = newr;
            pos_prev_in = posj_ff;
            p_prev_in   = pj_ff;
            res_cost_in = lwli_pkg::cost_min(newl_ff, newr);
            priority if (j_ff != n_ff) begin
               j_in     = j_ff + NW'(1);
               state_in = ST_CRD;
            end else if (i_ff == NW'(1)) begin
               state_in = ST_OUT;
            end else begin
               i_in     = i_ff - NW'(1);
               state_in = ST_ROW0;
            end
         end
         ST_OUT: begin
            if (slot_free) begin
               rsp_valid_in         = 1'b1;
               rsp_data_in.min_cost = res_cost_ff;
               rsp_data_in.status   = res_status_ff;
               state_in             = ST_IDLE;
            end
         end
         default: begin
            state_in = ST_IDLE;
         end
      endcase
   end

   // Control registers
   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= ST_IDLE;
         cnt_ff       <= '0;
         psum_ff      <= '0;
         viol_ff      <= 1'b0;
         start_ff     <= lwli_pkg::CIDX_W'(1);
         rsp_valid_ff <= 1'b0;
      end else begin
         state_ff     <= state_in;
         cnt_ff       <= cnt_in;
         psum_ff      <= psum_in;
         viol_ff      <= viol_in;
         rsp_valid_ff <= rsp_valid_in;
         if (csr_valid && csr_ready) begin
            start_ff <= csr_data;
         end
      end
   end

   // Payload registers
   always_ff @(posedge clock) begin
      lastpos_ff    <= lastpos_in;
      n_ff          <= n_in;
      pn_ff         <= pn_in;
      i_ff          <= i_in;
      j_ff          <= j_in;
      p_i_ff        <= p_i_in;
      p_im1_ff      <= p_im1_in;
      p_prev_ff     <= p_prev_in;
      pj_ff         <= pj_in;
      pos_i_ff      <= pos_i_in;
      pos_i1_ff     <= pos_i1_in;
      pos_prev_ff   <= pos_prev_in;
      posj_ff       <= posj_in;
      prevl_ff      <= prevl_in;
      prevr_ff      <= prevr_in;
      oldl_ff       <= oldl_in;
      oldr_ff       <= oldr_in;
      acc_ff        <= acc_in;
      newl_ff       <= newl_in;
      prod_ff       <= prod_in;
      res_cost_ff   <= res_cost_in;
      res_status_ff <= res_status_in;
      rsp_data_ff   <= rsp_data_in;
   end

   // Cells always lie right of the left end and within the loaded set
   a_cell_range: assert property (@(posedge clock) disable iff (reset)
      (state_ff == ST_CRD) |-> ((i_ff < j_ff) && (j_ff <= n_ff)))
      else $error("DP cell outside the loaded interval");

   // An error status never carries a cost
   a_err_cost: assert property (@(posedge clock) disable iff (reset)
      (rsp_valid && (rsp_data.status != lwli_pkg::STATUS_OK)) |-> (rsp_data.min_cost == '0))
      else $error("nonzero cost with error status");

   // Point count stays within the store
   a_cnt_bound: assert property (@(posedge clock) disable iff (reset)
      cnt_ff <= NW'(MAX_POINTS))
      else $error("point count beyond store depth");

endmodule

// File: rtl/lwli_ram.sv
module lwli_ram #(
   parameter int DEPTH = lwli_pkg::MAX_POINTS_DEF,
   parameter int AW    = 6,
   parameter int DW    = 8
) (
   input  logic          clock,
   input  logic          wr_en,
   input  logic [AW-1:0] wr_addr,
   input  logic [DW-1:0] wr_data,
   input  logic [AW-1:0] rd_addr,
   output logic [DW-1:0] rd_data
);

   logic [DW-1:0] mem [DEPTH];
   logic [DW-1:0] rd_data_ff;

   // Write port
   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem[wr_addr] <= wr_data;
      end
   end

   // Registered read port
   always_ff @(posedge clock) begin
      rd_data_ff <= mem[rd_addr];
   end

   assign rd_data = rd_data_ff;

endmodule
